FILE: rtl/core/websocket_frame_deframer_top_defines.svh
// Assertion macros shared by the deframer RTL.
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define WSFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define WSFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/core/wsfd_pkg.sv
// Types and constants of the WebSocket frame deframer.
`default_nettype none

package wsfd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    CMD_MSG   = 3'd0,
    CMD_END   = 3'd1,
    CMD_RBYTE = 3'd2,
    CMD_RHDR  = 3'd3,
    CMD_ERR   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    LF_SHORT = 2'd0,
    LF_16    = 2'd1,
    LF_64    = 2'd2
  } len_form_e;

  localparam logic [1:0] KIND_MSG   = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_REPLY = 2'd2;
  localparam logic [1:0] KIND_ERR   = 2'd3;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_CLOSED = 2'd1;
  localparam logic [1:0] ERR_CTRL   = 2'd2;
  localparam logic [1:0] ERR_FRAG   = 2'd3;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [6:0] LEN7_EXT64 = 7'h7F;
  localparam logic [6:0] LEN7_EXT16 = 7'h7E;
  localparam logic [6:0] LEN7_MAX   = 7'h7D;
  localparam logic [7:0] HDR_FIN    = 8'h80;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] MASK_BYTES  = 4'd4;

  localparam logic [3:0] STEP_SHORT_LAST = 4'd1;
  localparam logic [3:0] STEP_16_LAST    = 4'd3;
  localparam logic [3:0] STEP_64_LAST    = 4'd9;

  typedef struct packed {
    cmd_e        kind;
    logic [7:0]  data;
    logic [3:0]  opcode;
    logic        last;
    logic        fail_after;
    logic [1:0]  err;
    len_form_e   form;
    logic        empty;
    logic [63:0] len;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [3:0] opcode;
    logic       last;
    logic [1:0] err;
  } item_t;

endpackage

`default_nettype wire

FILE: rtl/core/websocket_frame_deframer_top.sv
// Top level of the WebSocket frame deframer.
//
// Channel | Dir | Bus         | Contents
// s_axis  | in  | tdata[7:0]  | rx_byte
// m_axis  | out | tdata[15:0] | data_byte, message_opcode, error_code
//         |     | tuser[1:0]  | kind
//         |     | tlast       | last
//
// One received word per cycle; the parser decides each word in the cycle it is taken.
// A reply header expands into up to ten output words, one per cycle, from the sequencer.
// Input stalls only while the command queue is full; output stalls back up into it.
// Reset is asynchronous, active low, and clears parser state and the queue; no clearing pass.
// A protocol error or a received close halts the parser until reset; input is still drained.
`default_nettype none

module websocket_frame_deframer_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [7:0] data_byte, [11:8] message_opcode,
                                             // [13:12] error_code, [15:14] zero
  output logic [1:0]       m_axis_tuser_o,   // [1:0] kind
  output logic             m_axis_tlast_o
);

  wsfd_pkg::cmd_t  cmd;
  wsfd_pkg::cmd_t  head;
  wsfd_pkg::item_t item;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;

  wsfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (s_axis_tvalid_i),
    .rx_ready_o (s_axis_tready_o),
    .rx_byte_i  (s_axis_tdata_i),
    .q_full_i   (q_full),
    .cmd_push_o (push),
    .cmd_o      (cmd)
  );

  wsfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  wsfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .item_o      (item)
  );

  assign m_axis_tdata_o = {2'b00, item.err, item.opcode, item.data};
  assign m_axis_tuser_o = item.kind;
  assign m_axis_tlast_o = item.last;

endmodule

`default_nettype wire

FILE: rtl/core/wsfd_front.sv
// Header parser and unmasker; turns each received byte into at most one command.
`default_nettype none
`include "websocket_frame_deframer_top_defines.svh"

module wsfd_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            rx_valid_i,
  output logic                 rx_ready_o,
  input  wire logic [7:0]      rx_byte_i,
  input  wire logic            q_full_i,
  output logic                 cmd_push_o,
  output wsfd_pkg::cmd_t       cmd_o
);

  wsfd_pkg::phase_e phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        fin_q, fin_d;
  logic        mask_q, mask_d;
  logic [3:0]  lbl_q, lbl_d;
  logic [63:0] pl_q, pl_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  pidx_q, pidx_d;
  logic [3:0]  cur_q, cur_d;
  logic        halted_q, halted_d;

  logic        accept;
  logic        hdr_done;
  logic        empty;
  logic        pend;
  logic        cmd_valid;
  logic [3:0]  cur_new;
  logic [7:0]  key_byte;
  logic [7:0]  unmasked;
  wsfd_pkg::cmd_t cmd;

  assign rx_ready_o = !q_full_i;
  assign accept     = rx_valid_i && rx_ready_o;
  assign cmd_push_o = accept && cmd_valid;
  assign cmd_o      = cmd;

  always_comb begin
    unique case (pidx_q)
      2'd0: key_byte = key_q[31:24];
      2'd1: key_byte = key_q[23:16];
      2'd2: key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
    unmasked = rx_byte_i ^ (mask_q ? key_byte : 8'h00);
  end

  always_comb begin
    phase_d   = phase_q;
    opcode_d  = opcode_q;
    fin_d     = fin_q;
    mask_d    = mask_q;
    lbl_d     = lbl_q;
    pl_d      = pl_q;
    key_d     = key_q;
    pidx_d    = pidx_q;
    cur_d     = cur_q;
    halted_d  = halted_q;
    hdr_done  = 1'b0;
    empty     = 1'b0;
    pend      = 1'b0;
    cur_new   = cur_q;
    cmd_valid = 1'b0;
    cmd       = wsfd_pkg::cmd_t'('0);

    if (accept && !halted_q) begin
      unique case (phase_q)
        wsfd_pkg::PH_HDR1: begin
          mask_d = rx_byte_i[7];
          key_d  = 32'h0;
          pl_d   = 64'h0;
          if (rx_byte_i[6:0] == wsfd_pkg::LEN7_EXT64) begin
            lbl_d   = wsfd_pkg::EXT64_BYTES;
            phase_d = wsfd_pkg::PH_EXTLEN;
          end else if (rx_byte_i[6:0] == wsfd_pkg::LEN7_EXT16) begin
            lbl_d   = wsfd_pkg::EXT16_BYTES;
            phase_d = wsfd_pkg::PH_EXTLEN;
          end else begin
            pl_d = {57'h0, rx_byte_i[6:0]};
            if (rx_byte_i[7]) begin
              lbl_d   = wsfd_pkg::MASK_BYTES;
              phase_d = wsfd_pkg::PH_MASK;
            end else begin
              hdr_done = 1'b1;
            end
          end
        end
        wsfd_pkg::PH_EXTLEN: begin
          pl_d  = {pl_q[55:0], rx_byte_i};
          lbl_d = lbl_q - 4'd1;
          if (lbl_d == 4'd0) begin
            if (mask_q) begin
              lbl_d   = wsfd_pkg::MASK_BYTES;
              phase_d = wsfd_pkg::PH_MASK;
            end else begin
              hdr_done = 1'b1;
            end
          end
        end
        wsfd_pkg::PH_MASK: begin
          key_d = {key_q[23:0], rx_byte_i};
          lbl_d = lbl_q - 4'd1;
          if (lbl_d == 4'd0) begin
            hdr_done = 1'b1;
          end
        end
        wsfd_pkg::PH_PAYLOAD: begin
          pidx_d = pidx_q + 2'd1;
          pl_d   = pl_q - 64'd1;
          pend   = (pl_q == 64'd1);
          if (pend) begin
            phase_d = wsfd_pkg::PH_HDR0;
          end
          if (opcode_q[3]) begin
            if (opcode_q != wsfd_pkg::OP_PONG) begin
              cmd_valid       = 1'b1;
              cmd.kind        = wsfd_pkg::CMD_RBYTE;
              cmd.data        = unmasked;
              cmd.last        = pend;
              cmd.fail_after  = pend && (opcode_q == wsfd_pkg::OP_CLOSE);
              halted_d        = cmd.fail_after;
            end
          end else begin
            cmd_valid   = 1'b1;
            cmd.kind    = wsfd_pkg::CMD_MSG;
            cmd.data    = unmasked;
            cmd.opcode  = cur_q;
            cmd.last    = pend && fin_q;
            if (pend && fin_q) begin
              cur_d = wsfd_pkg::OP_CONT;
            end
          end
        end
        default: begin
          fin_d    = rx_byte_i[7];
          opcode_d = rx_byte_i[3:0];
          phase_d  = wsfd_pkg::PH_HDR1;
        end
      endcase

      if (hdr_done) begin
        empty   = (pl_d == 64'h0);
        pidx_d  = 2'd0;
        phase_d = empty ? wsfd_pkg::PH_HDR0 : wsfd_pkg::PH_PAYLOAD;
        if (opcode_q[3]) begin
          if (opcode_q == wsfd_pkg::OP_CLOSE || opcode_q == wsfd_pkg::OP_PING) begin
            cmd_valid      = 1'b1;
            cmd.kind       = wsfd_pkg::CMD_RHDR;
            cmd.opcode     = (opcode_q == wsfd_pkg::OP_PING) ? wsfd_pkg::OP_PONG
                                                             : wsfd_pkg::OP_CLOSE;
            cmd.len        = pl_d;
            cmd.empty      = empty;
            cmd.fail_after = empty && (opcode_q == wsfd_pkg::OP_CLOSE);
            halted_d       = cmd.fail_after;
            if (|pl_d[63:16]) begin
              cmd.form = wsfd_pkg::LF_64;
            end else if (pl_d[15:0] > {9'h0, wsfd_pkg::LEN7_MAX}) begin
              cmd.form = wsfd_pkg::LF_16;
            end else begin
              cmd.form = wsfd_pkg::LF_SHORT;
            end
          end else if (opcode_q != wsfd_pkg::OP_PONG) begin
            cmd_valid = 1'b1;
            cmd.kind  = wsfd_pkg::CMD_ERR;
            cmd.err   = wsfd_pkg::ERR_CTRL;
            halted_d  = 1'b1;
            phase_d   = wsfd_pkg::PH_HDR0;
          end
        end else if ((cur_q == wsfd_pkg::OP_CONT) == (opcode_q == wsfd_pkg::OP_CONT)) begin
          cmd_valid = 1'b1;
          cmd.kind  = wsfd_pkg::CMD_ERR;
          cmd.err   = wsfd_pkg::ERR_FRAG;
          halted_d  = 1'b1;
          phase_d   = wsfd_pkg::PH_HDR0;
        end else begin
          cur_new = (opcode_q != wsfd_pkg::OP_CONT) ? opcode_q : cur_q;
          cur_d   = cur_new;
          if (empty && fin_q) begin
            cmd_valid  = 1'b1;
            cmd.kind   = wsfd_pkg::CMD_END;
            cmd.opcode = cur_new;
            cmd.last   = 1'b1;
            cur_d      = wsfd_pkg::OP_CONT;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= wsfd_pkg::PH_HDR0;
      opcode_q <= 4'h0;
      fin_q    <= 1'b0;
      mask_q   <= 1'b0;
      lbl_q    <= 4'h0;
      pl_q     <= 64'h0;
      key_q    <= 32'h0;
      pidx_q   <= 2'd0;
      cur_q    <= wsfd_pkg::OP_CONT;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      fin_q    <= fin_d;
      mask_q   <= mask_d;
      lbl_q    <= lbl_d;
      pl_q     <= pl_d;
      key_q    <= key_d;
      pidx_q   <= pidx_d;
      cur_q    <= cur_d;
      halted_q <= halted_d;
    end
  end

  `WSFD_ASSERT(a_halt_sticky, halted_q |=> halted_q, "halt released without reset")
  `WSFD_ASSERT_ALWAYS(a_halt_silent, halted_q |-> !cmd_push_o, "command after halt")
  `WSFD_ASSERT(a_payload_nonzero, (phase_q == wsfd_pkg::PH_PAYLOAD) |-> (pl_q != 64'h0),
               "payload phase with no bytes left")

endmodule

`default_nettype wire

FILE: rtl/core/wsfd_queue.sv
// Command queue between the parser and the result sequencer.
`default_nettype none
`include "websocket_frame_deframer_top_defines.svh"

module wsfd_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire wsfd_pkg::cmd_t cmd_i,
  input  wire logic           pop_i,
  output wsfd_pkg::cmd_t      head_o,
  output logic                full_o,
  output logic                empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);
  localparam logic [PtrW-1:0] PtrOne  = PtrW'(1);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  wsfd_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + PtrOne;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + PtrOne;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntOne;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntOne;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `WSFD_ASSERT(a_cnt_range, cnt_q <= CntFull, "queue count beyond depth")
  `WSFD_ASSERT(a_no_overflow, push_i |-> !full_o, "push into full queue")
  `WSFD_ASSERT(a_no_underflow, pop_i |-> !empty_o, "pop from empty queue")

endmodule

`default_nettype wire

FILE: rtl/core/wsfd_back.sv
// Result sequencer: expands queued commands into output words.
`default_nettype none

module wsfd_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire wsfd_pkg::cmd_t  head_i,
  input  wire logic            q_empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output wsfd_pkg::item_t      item_o
);

  logic [3:0]      step_q, step_d;
  logic            valid_q, valid_d;
  wsfd_pkg::item_t item_q, item_d;
  wsfd_pkg::item_t item;
  logic [3:0]      hdr_last;
  logic [3:0]      last_step;
  logic [2:0]      byte_sel;
  logic [7:0]      len_byte;
  logic            out_free;
  logic            advance;

  function automatic logic [7:0] pick_byte(input logic [63:0] len, input logic [2:0] k);
    logic [7:0] b;
    unique case (k)
      3'd0: b = len[63:56];
      3'd1: b = len[55:48];
      3'd2: b = len[47:40];
      3'd3: b = len[39:32];
      3'd4: b = len[31:24];
      3'd5: b = len[23:16];
      3'd6: b = len[15:8];
      default: b = len[7:0];
    endcase
    return b;
  endfunction

  assign out_free    = !valid_q || out_ready_i;
  assign advance     = !q_empty_i && out_free;
  assign pop_o       = advance && (step_q == last_step);
  assign out_valid_o = valid_q;
  assign item_o      = item_q;

  always_comb begin
    unique case (head_i.form)
      wsfd_pkg::LF_64: hdr_last = wsfd_pkg::STEP_64_LAST;
      wsfd_pkg::LF_16: hdr_last = wsfd_pkg::STEP_16_LAST;
      default:         hdr_last = wsfd_pkg::STEP_SHORT_LAST;
    endcase
    unique case (head_i.kind)
      wsfd_pkg::CMD_RHDR:  last_step = hdr_last + {3'd0, head_i.fail_after};
      wsfd_pkg::CMD_RBYTE: last_step = {3'd0, head_i.fail_after};
      default:             last_step = 4'd0;
    endcase
    byte_sel = 3'(step_q - 4'd2);
    len_byte = pick_byte(head_i.len, byte_sel);

    item        = wsfd_pkg::item_t'('0);
    item.kind   = wsfd_pkg::KIND_REPLY;
    unique case (head_i.kind)
      wsfd_pkg::CMD_MSG: begin
        item.kind   = wsfd_pkg::KIND_MSG;
        item.data   = head_i.data;
        item.opcode = head_i.opcode;
        item.last   = head_i.last;
      end
      wsfd_pkg::CMD_END: begin
        item.kind   = wsfd_pkg::KIND_END;
        item.opcode = head_i.opcode;
        item.last   = 1'b1;
      end
      wsfd_pkg::CMD_RBYTE: begin
        if (step_q == 4'd0) begin
          item.data = head_i.data;
          item.last = head_i.last;
        end else begin
          item.kind = wsfd_pkg::KIND_ERR;
          item.err  = wsfd_pkg::ERR_CLOSED;
        end
      end
      wsfd_pkg::CMD_RHDR: begin
        if (step_q == 4'd0) begin
          item.data = wsfd_pkg::HDR_FIN | {4'h0, head_i.opcode};
        end else if (step_q > hdr_last) begin
          item.kind = wsfd_pkg::KIND_ERR;
          item.err  = wsfd_pkg::ERR_CLOSED;
        end else begin
          item.last = head_i.empty && (step_q == hdr_last);
          unique case (head_i.form)
            wsfd_pkg::LF_64: begin
              item.data = (step_q == 4'd1) ? {1'b0, wsfd_pkg::LEN7_EXT64} : len_byte;
            end
            wsfd_pkg::LF_16: begin
              if (step_q == 4'd1) begin
                item.data = {1'b0, wsfd_pkg::LEN7_EXT16};
              end else if (step_q == 4'd2) begin
                item.data = head_i.len[15:8];
              end else begin
                item.data = head_i.len[7:0];
              end
            end
            default: item.data = head_i.len[7:0];
          endcase
        end
      end
      default: begin
        item.kind = wsfd_pkg::KIND_ERR;
        item.err  = head_i.err;
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    step_d  = step_q;
    if (out_free) begin
      valid_d = !q_empty_i;
    end
    if (advance) begin
      item_d = item;
      step_d = pop_o ? 4'd0 : step_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= 4'd0;
    end else begin
      valid_q <= valid_d;
      step_q  <= step_d;
    end
  end

endmodule

`default_nettype wire

FILE: test/websocket_frame_deframer_top_test.sv
// Self-checking stream testbench for the WebSocket frame deframer top level.
`timescale 1ns / 100ps

module websocket_frame_deframer_top_test;

  localparam logic [3:0] OP_TEXT      = 4'h1;
  localparam logic [3:0] OP_BINARY    = 4'h2;
  localparam logic [3:0] NO_OPCODE    = 4'h0;
  localparam int         STALL_LIMIT  = 1000;
  localparam int         HOLD_CYCLES  = 80;
  localparam int         RANDOM_WORDS = 220;

  typedef struct packed {
    logic [7:0] value;
    logic       drain_first;
  } rx_word_t;

  typedef enum int {
    END_CLOSE_EMPTY, END_CLOSE_BODY, END_BAD_CTRL, END_STRAY_CONT,
    END_NESTED_DATA, END_HUGE_PING, END_HUGE_DATA
  } tail_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;  // [7:0] data_byte, [11:8] message_opcode, [13:12] error_code
  logic [1:0]  m_axis_tuser_o;  // [1:0] kind
  logic        m_axis_tlast_o;

  // parser state of the deframer as predicted
  wsfd_pkg::phase_e rx_phase = wsfd_pkg::PH_HDR0;
  logic [3:0]  hdr_opcode = 4'h0;
  logic        hdr_fin = 1'b0;
  logic        hdr_masked = 1'b0;
  logic [3:0]  hdr_bytes_left = 4'h0;
  logic [63:0] body_left = 64'h0;
  logic [31:0] mask_word = 32'h0;
  logic [1:0]  mask_idx = 2'h0;
  logic [3:0]  open_opcode = 4'h0;
  logic        parser_halted = 1'b0;

  wsfd_pkg::item_t expected_q[$];
  rx_word_t    rx_word_q[$];
  wsfd_pkg::item_t want;
  logic        drain_next = 1'b0;
  int          n_accepted = 0;
  int          offer_mark = -1;
  int          tx_gap = 0;
  int          rx_stall = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  int          hold_at = 0;
  int          quiet_from = 0;
  int          idle_cycles = 0;
  int          fail_count = 0;

  websocket_frame_deframer_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic push_result(input logic [1:0] kind, input logic [7:0] data,
                             input logic [3:0] opcode, input logic last,
                             input logic [1:0] err);
    wsfd_pkg::item_t r;
    r.kind = kind;
    r.data = data;
    r.opcode = opcode;
    r.last = last;
    r.err = err;
    expected_q.insert(expected_q.size(), r);
  endtask

  task automatic halt_with(input logic [1:0] err);
    parser_halted = 1'b1;
    rx_phase = wsfd_pkg::PH_HDR0;
    push_result(wsfd_pkg::KIND_ERR, 8'h00, NO_OPCODE, 1'b0, err);
  endtask

  task automatic push_reply_header(input logic [3:0] opcode, input logic [63:0] len);
    logic no_body;
    no_body = (len == 64'd0);
    push_result(wsfd_pkg::KIND_REPLY, wsfd_pkg::HDR_FIN | {4'h0, opcode}, NO_OPCODE, 1'b0,
                wsfd_pkg::ERR_NONE);
    if (len > 64'd65535) begin
      push_result(wsfd_pkg::KIND_REPLY, {1'b0, wsfd_pkg::LEN7_EXT64}, NO_OPCODE, 1'b0,
                  wsfd_pkg::ERR_NONE);
      for (int i = 7; i >= 0; i--)
        push_result(wsfd_pkg::KIND_REPLY, len[8*i +: 8], NO_OPCODE, (i == 0) && no_body,
                    wsfd_pkg::ERR_NONE);
    end else if (len > 64'(wsfd_pkg::LEN7_MAX)) begin
      push_result(wsfd_pkg::KIND_REPLY, {1'b0, wsfd_pkg::LEN7_EXT16}, NO_OPCODE, 1'b0,
                  wsfd_pkg::ERR_NONE);
      push_result(wsfd_pkg::KIND_REPLY, len[15:8], NO_OPCODE, 1'b0, wsfd_pkg::ERR_NONE);
      push_result(wsfd_pkg::KIND_REPLY, len[7:0], NO_OPCODE, no_body, wsfd_pkg::ERR_NONE);
    end else begin
      push_result(wsfd_pkg::KIND_REPLY, len[7:0], NO_OPCODE, no_body, wsfd_pkg::ERR_NONE);
    end
  endtask

  task automatic finish_header();
    logic no_body;
    no_body = (body_left == 64'd0);
    mask_idx = 2'd0;
    if (no_body) rx_phase = wsfd_pkg::PH_HDR0;
    else rx_phase = wsfd_pkg::PH_PAYLOAD;
    if (hdr_opcode[3]) begin
      if (hdr_opcode == wsfd_pkg::OP_CLOSE || hdr_opcode == wsfd_pkg::OP_PING) begin
        if (hdr_opcode == wsfd_pkg::OP_PING) push_reply_header(wsfd_pkg::OP_PONG, body_left);
        else push_reply_header(wsfd_pkg::OP_CLOSE, body_left);
        if (no_body && hdr_opcode == wsfd_pkg::OP_CLOSE) halt_with(wsfd_pkg::ERR_CLOSED);
      end else if (hdr_opcode != wsfd_pkg::OP_PONG) begin
        halt_with(wsfd_pkg::ERR_CTRL);
      end
    end else if ((open_opcode == wsfd_pkg::OP_CONT) == (hdr_opcode == wsfd_pkg::OP_CONT)) begin
      halt_with(wsfd_pkg::ERR_FRAG);
    end else begin
      if (hdr_opcode != wsfd_pkg::OP_CONT) open_opcode = hdr_opcode;
      if (no_body && hdr_fin) begin
        push_result(wsfd_pkg::KIND_END, 8'h00, open_opcode, 1'b1, wsfd_pkg::ERR_NONE);
        open_opcode = wsfd_pkg::OP_CONT;
      end
    end
  endtask

  task automatic take_payload(input logic [7:0] b);
    logic [7:0] d;
    logic       at_end;
    d = b;
    if (hdr_masked) d = b ^ mask_word[31 - 8*mask_idx -: 8];
    mask_idx = mask_idx + 2'd1;
    body_left = body_left - 64'd1;
    at_end = (body_left == 64'd0);
    if (at_end) rx_phase = wsfd_pkg::PH_HDR0;
    if (hdr_opcode[3]) begin
      if (hdr_opcode != wsfd_pkg::OP_PONG) begin
        push_result(wsfd_pkg::KIND_REPLY, d, NO_OPCODE, at_end, wsfd_pkg::ERR_NONE);
        if (at_end && hdr_opcode == wsfd_pkg::OP_CLOSE) halt_with(wsfd_pkg::ERR_CLOSED);
      end
    end else begin
      push_result(wsfd_pkg::KIND_MSG, d, open_opcode, at_end && hdr_fin, wsfd_pkg::ERR_NONE);
      if (at_end && hdr_fin) open_opcode = wsfd_pkg::OP_CONT;
    end
  endtask

  task automatic predict_rx_byte(input logic [7:0] b);
    if (!parser_halted) begin
      case (rx_phase)
        wsfd_pkg::PH_HDR1: begin
          hdr_masked = b[7];
          mask_word = 32'h0;
          body_left = 64'(b[6:0]);
          if (b[6:0] == wsfd_pkg::LEN7_EXT64 || b[6:0] == wsfd_pkg::LEN7_EXT16) begin
            if (b[6:0] == wsfd_pkg::LEN7_EXT64) hdr_bytes_left = wsfd_pkg::EXT64_BYTES;
            else hdr_bytes_left = wsfd_pkg::EXT16_BYTES;
            body_left = 64'h0;
            rx_phase = wsfd_pkg::PH_EXTLEN;
          end else if (hdr_masked) begin
            hdr_bytes_left = wsfd_pkg::MASK_BYTES;
            rx_phase = wsfd_pkg::PH_MASK;
          end else begin
            finish_header();
          end
        end
        wsfd_pkg::PH_EXTLEN: begin
          body_left = {body_left[55:0], b};
          hdr_bytes_left = hdr_bytes_left - 4'd1;
          if (hdr_bytes_left == 4'd0) begin
            if (hdr_masked) begin
              hdr_bytes_left = wsfd_pkg::MASK_BYTES;
              rx_phase = wsfd_pkg::PH_MASK;
            end else begin
              finish_header();
            end
          end
        end
        wsfd_pkg::PH_MASK: begin
          mask_word = {mask_word[23:0], b};
          hdr_bytes_left = hdr_bytes_left - 4'd1;
          if (hdr_bytes_left == 4'd0) finish_header();
        end
        wsfd_pkg::PH_PAYLOAD: take_payload(b);
        default: begin
          hdr_fin = b[7];
          hdr_opcode = b[3:0];
          rx_phase = wsfd_pkg::PH_HDR1;
        end
      endcase
    end
  endtask

  task automatic put_byte(input logic [7:0] value);
    rx_word_t w;
    w.value = value;
    w.drain_first = drain_next;
    drain_next = 1'b0;
    rx_word_q.insert(rx_word_q.size(), w);
  endtask

  task automatic add_frame(input logic fin, input logic [3:0] opcode, input logic [63:0] len,
                           input wsfd_pkg::len_form_e form, input logic masked,
                           input int body_count);
    logic [31:0] key;
    logic [7:0]  fill;
    key = $urandom();
    put_byte({fin, 3'($urandom_range(0, 7)), opcode});
    case (form)
      wsfd_pkg::LF_16: begin
        put_byte({masked, wsfd_pkg::LEN7_EXT16});
        put_byte(len[15:8]);
        put_byte(len[7:0]);
      end
      wsfd_pkg::LF_64: begin
        put_byte({masked, wsfd_pkg::LEN7_EXT64});
        for (int i = 7; i >= 0; i--) put_byte(len[8*i +: 8]);
      end
      default: put_byte({masked, len[6:0]});
    endcase
    if (masked) for (int i = 3; i >= 0; i--) put_byte(key[8*i +: 8]);
    for (int i = 0; i < body_count; i++) begin
      case ($urandom_range(0, 7))
        0: fill = 8'h00;
        1: fill = 8'hFF;
        default: fill = 8'($urandom_range(0, 255));
      endcase
      put_byte(fill);
    end
  endtask

  function automatic wsfd_pkg::len_form_e pick_form(input logic [63:0] len);
    int roll;
    roll = $urandom_range(0, 4);
    if (len > 64'd65535) return wsfd_pkg::LF_64;
    if (len > 64'(wsfd_pkg::LEN7_MAX)) begin
      if (roll < 3) return wsfd_pkg::LF_16;
      return wsfd_pkg::LF_64;
    end
    if (roll == 3) return wsfd_pkg::LF_16;
    if (roll == 4) return wsfd_pkg::LF_64;
    return wsfd_pkg::LF_SHORT;
  endfunction

  function automatic logic [63:0] pick_len();
    if ($urandom_range(0, 39) == 0) return 64'($urandom_range(126, 140));
    return 64'($urandom_range(0, 6));
  endfunction

  task automatic add_control();
    logic [63:0] len;
    logic [3:0]  opcode;
    len = pick_len();
    if ($urandom_range(0, 1) == 0) opcode = wsfd_pkg::OP_PING;
    else opcode = wsfd_pkg::OP_PONG;
    add_frame(1'($urandom_range(0, 1)), opcode, len, pick_form(len),
              1'($urandom_range(0, 1)), int'(len));
  endtask

  task automatic add_tail();
    tail_e       tail;
    logic [63:0] len;
    tail = tail_e'($urandom_range(0, 6));
    len = {32'($urandom()), 32'($urandom())} | 64'h1_0000;
    case (tail)
      END_CLOSE_EMPTY: add_frame(1'b1, wsfd_pkg::OP_CLOSE, 64'd0, pick_form(64'd0),
                                 1'($urandom_range(0, 1)), 0);
      END_CLOSE_BODY: add_frame(1'b1, wsfd_pkg::OP_CLOSE, 64'd3, wsfd_pkg::LF_SHORT, 1'b1, 3);
      END_BAD_CTRL: add_frame(1'b1, 4'($urandom_range(11, 15)), 64'd2, wsfd_pkg::LF_SHORT,
                              1'b0, 2);
      END_STRAY_CONT: add_frame(1'b1, wsfd_pkg::OP_CONT, 64'd1, wsfd_pkg::LF_SHORT,
                                1'($urandom_range(0, 1)), 1);
      END_NESTED_DATA: begin
        add_frame(1'b0, OP_TEXT, 64'd2, wsfd_pkg::LF_SHORT, 1'b1, 2);
        add_frame(1'b1, OP_BINARY, 64'd1, wsfd_pkg::LF_SHORT, 1'b0, 1);
      end
      END_HUGE_PING: add_frame(1'b1, wsfd_pkg::OP_PING, len, wsfd_pkg::LF_64,
                               1'($urandom_range(0, 1)), 5);
      default: add_frame(1'($urandom_range(0, 1)), 4'($urandom_range(1, 7)), len,
                         wsfd_pkg::LF_64, 1'($urandom_range(0, 1)), 6);
    endcase
    for (int i = 0; i < 8; i++) put_byte(8'($urandom_range(0, 255)));
  endtask

  function automatic logic idling_on();
    return n_accepted < quiet_from && (n_accepted / 32) % 3 != 2;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want_v, input logic [7:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want_v, got_v);
      fail_count++;
    end
  endtask

  // sender
  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid_i && offer_mark == n_accepted)) begin
      if (tx_gap != 0) begin
        tx_gap = tx_gap - 1;
        s_axis_tvalid_i <= 1'b0;
      end else if (rx_word_q.size() == 0 ||
                   (rx_word_q[0].drain_first && expected_q.size() != 0)) begin
        s_axis_tvalid_i <= 1'b0;
      end else begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= rx_word_q[0].value;
        offer_mark = n_accepted;
        if (idling_on() && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 17);
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        m_axis_tready_i <= 1'b0;
      end else if (!hold_done && n_accepted >= hold_at) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        m_axis_tready_i <= 1'b0;
      end else if (rx_stall != 0) begin
        rx_stall = rx_stall - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (idling_on() && $urandom_range(0, 5) == 0) rx_stall = $urandom_range(1, 17);
      end
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_rx_byte(s_axis_tdata_i);
        void'(rx_word_q.pop_front());
        n_accepted++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual tuser 0x%0h tdata 0x%0h tlast %0b",
                   $time, m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("kind", 8'(want.kind), 8'(m_axis_tuser_o));
          check_field("data_byte", want.data, m_axis_tdata_o[7:0]);
          check_field("message_opcode", 8'(want.opcode), 8'(m_axis_tdata_o[11:8]));
          check_field("last", 8'(want.last), 8'(m_axis_tlast_o));
          check_field("error_code", 8'(want.err), 8'(m_axis_tdata_o[13:12]));
        end
      end
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int          directed_end;
    int          nfrag;
    logic [63:0] len;
    logic        drain_set;

    drain_set = 1'b0;
    add_frame(1'b0, OP_BINARY, 64'd3, wsfd_pkg::LF_SHORT, 1'b1, 3);
    add_frame(1'b1, wsfd_pkg::OP_PONG, 64'd1, wsfd_pkg::LF_SHORT, 1'b0, 1);
    add_frame(1'b1, wsfd_pkg::OP_PING, 64'd2, wsfd_pkg::LF_SHORT, 1'b0, 2);
    add_frame(1'b1, wsfd_pkg::OP_PING, 64'd0, wsfd_pkg::LF_SHORT, 1'b1, 0);
    add_frame(1'b0, wsfd_pkg::OP_CONT, 64'd0, wsfd_pkg::LF_SHORT, 1'b0, 0);
    add_frame(1'b1, wsfd_pkg::OP_CONT, 64'd0, wsfd_pkg::LF_16, 1'b0, 0);
    directed_end = rx_word_q.size();
    hold_at = directed_end + 40;

    while (rx_word_q.size() < directed_end + RANDOM_WORDS) begin
      if ($urandom_range(0, 3) == 0) begin
        add_control();
      end else begin
        nfrag = $urandom_range(1, 3);
        for (int f = 0; f < nfrag; f++) begin
          if (f > 0 && $urandom_range(0, 2) == 0) add_control();
          len = pick_len();
          add_frame(1'(f == nfrag - 1), (f == 0) ? 4'($urandom_range(1, 7)) : wsfd_pkg::OP_CONT,
                    len, pick_form(len), 1'($urandom_range(0, 1)), int'(len));
        end
      end
      if (!drain_set && rx_word_q.size() > directed_end + 150) begin
        drain_next = 1'b1;
        drain_set = 1'b1;
      end
    end
    add_tail();
    quiet_from = rx_word_q.size() - 40;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (rx_word_q.size() != 0 || expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
